// ===== rtl/ibfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfc_pkg
// Shared constants and types of the IMU burst frame checker.
// ----------------------------------------------------------------------------
package ibfc_pkg;

  localparam int WORD_W      = 16;
  localparam int NUM_SAMPLES = 11;
  localparam int NUM_BANKS   = 2;
  localparam int IDX_W       = 4;
  localparam int CH_W        = 4;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [WORD_W-1:0] FAIL_MAX = 16'hFFFF;

  // Word positions inside a frame.
  localparam logic [3:0] POS_IDLE  = 4'd0;
  localparam logic [3:0] POS_DIAG  = 4'd1;
  localparam logic [3:0] POS_FIRST = 4'd2;
  localparam logic [3:0] POS_LAST  = 4'd12;

  // Channel codes.
  localparam logic [CH_W-1:0] CH_GYRO_X    = 4'd0;
  localparam logic [CH_W-1:0] CH_ACCEL_Z   = 4'd5;
  localparam logic [CH_W-1:0] CH_TEMP      = 4'd10;
  localparam int              MAG_NEW_BIT  = 7;

  // One checked frame, handed from the front end to the result sequencer.
  typedef struct packed {
    logic              fail;
    logic              bank;
    logic              mag_en;
    logic [WORD_W-1:0] fail_count;
  } job_t;

  // Sample write from the front end into the banked sample store.
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  // A sample bank that the sequencer has finished reading.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

// ===== rtl/imu_burst_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_burst_frame_checker
// CRC check of 14-word inertial sensor burst frames with per-channel output.
// ----------------------------------------------------------------------------
// The block takes one frame word per clock cycle while in_full is low. Samples
// go into one of two sample banks while a 16-bit CRC runs over them; the
// checksum word queues a job for the result sequencer, which fetches the job
// and then delivers one result per cycle while the output is popped (7 or 11
// results for a good frame, one error result for a bad one). The input side stalls only when both sample banks
// still hold frames that the sequencer has not finished reading out, or when
// the two-entry job queue is full.
module imu_burst_frame_checker
  import ibfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [WORD_W-1:0] in_rx_word,
  input  logic              in_frame_start,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_status,
  output logic [CH_W-1:0]   out_channel,
  output logic [WORD_W-1:0] out_sample_value,
  output logic [WORD_W-1:0] out_fail_count,
  output logic              out_last_of_run
);

  logic      in_accept;
  logic      out_accept;
  logic      out_valid;
  logic      q_push, q_pop, q_full, q_empty;
  job_t      q_job_in, q_job_out;
  mem_wr_t   mem_wr;
  bank_rel_t bank_rel;

  assign in_accept  = in_push && !in_full;
  assign out_empty  = !out_valid;
  assign out_accept = out_pop && out_valid;

  ibfc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept_i      (in_accept),
    .rx_word_i     (in_rx_word),
    .frame_start_i (in_frame_start),
    .q_full_i      (q_full),
    .rel_i         (bank_rel),
    .full_o        (in_full),
    .q_push_o      (q_push),
    .q_job_o       (q_job_in),
    .mem_wr_o      (mem_wr)
  );

  ibfc_job_fifo u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .pop_i   (q_pop),
    .job_o   (q_job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ibfc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mem_wr_i       (mem_wr),
    .q_empty_i      (q_empty),
    .q_job_i        (q_job_out),
    .q_pop_o        (q_pop),
    .rel_o          (bank_rel),
    .pop_i          (out_accept),
    .out_valid_o    (out_valid),
    .status_o       (out_status),
    .channel_o      (out_channel),
    .sample_value_o (out_sample_value),
    .fail_count_o   (out_fail_count),
    .last_o         (out_last_of_run)
  );

`ifndef ASSERT_OFF
  // An error result is always the only result of its frame.
  a_err_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |-> (out_last_of_run && out_channel == CH_GYRO_X))
    else $error("error result not marked last or has a channel");

  // A good frame always ends on the temperature channel.
  a_good_ends_temp : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_status && out_last_of_run) |-> (out_channel == CH_TEMP))
    else $error("good frame ended on a channel other than temperature");

  // The front end never queues a job into a full queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

  // A sample write never lands in a bank the sequencer is still reading.
  a_bank_free : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr.en && q_pop) |-> (q_job_out.fail || q_job_out.bank != mem_wr.bank))
    else $error("sample write into a bank still awaiting readout");
`endif

endmodule

// ===== rtl/ibfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfc_front
// Frame tracker: follows word positions, runs the CRC, writes samples into
// the current bank and queues one job per completed frame.
// ----------------------------------------------------------------------------
module ibfc_front
  import ibfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept_i,
  input  logic [WORD_W-1:0] rx_word_i,
  input  logic              frame_start_i,
  input  logic              q_full_i,
  input  bank_rel_t         rel_i,
  output logic              full_o,
  output logic              q_push_o,
  output job_t              q_job_o,
  output mem_wr_t           mem_wr_o
);

  logic [3:0]           pos_r, pos_nxt;
  logic                 active_r, active_nxt;
  logic [WORD_W-1:0]    crc_r, crc_nxt;
  logic                 diag7_r, diag7_nxt;
  logic [WORD_W-1:0]    fail_r, fail_nxt;
  logic                 wbank_r, wbank_nxt;
  logic [NUM_BANKS-1:0] busy_r, busy_nxt;
  logic [WORD_W-1:0]    crc_inv;
  logic [WORD_W-1:0]    expect_word;

  // Right-shifting bit-serial CRC over one word, low bit first.
  function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] crc,
                                                 input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] c;
    c = crc;
    for (int b = 0; b < WORD_W; b++) begin
      if (c[0] ^ w[b]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  assign crc_inv     = ~crc_r;
  assign expect_word = {crc_inv[7:0], crc_inv[15:8]};

  // A bank still waiting to be drained cannot take the next frame's samples.
  assign full_o = q_full_i || busy_r[wbank_r];

  always_comb begin
    pos_nxt    = pos_r;
    active_nxt = active_r;
    crc_nxt    = crc_r;
    diag7_nxt  = diag7_r;
    fail_nxt   = fail_r;
    wbank_nxt  = wbank_r;
    busy_nxt   = busy_r;
    q_push_o   = 1'b0;
    q_job_o    = '0;
    mem_wr_o   = '0;

    if (rel_i.valid) begin
      busy_nxt[rel_i.bank] = 1'b0;
    end

    if (accept_i) begin
      if (frame_start_i) begin
        active_nxt = 1'b1;
        pos_nxt    = POS_DIAG;
        crc_nxt    = CRC_INIT;
      end else if (active_r) begin
        if (pos_r == POS_DIAG) begin
          diag7_nxt = rx_word_i[MAG_NEW_BIT];
          pos_nxt   = POS_FIRST;
        end else if (pos_r >= POS_FIRST && pos_r <= POS_LAST) begin
          mem_wr_o.en   = 1'b1;
          mem_wr_o.bank = wbank_r;
          mem_wr_o.idx  = IDX_W'(pos_r - POS_FIRST);
          mem_wr_o.data = rx_word_i;
          crc_nxt       = crc_word(crc_r, rx_word_i);
          pos_nxt       = 4'(pos_r + 4'd1);
        end else begin
          // Checksum word closes the frame.
          active_nxt = 1'b0;
          pos_nxt    = POS_IDLE;
          crc_nxt    = CRC_INIT;
          q_push_o   = 1'b1;
          if (rx_word_i != expect_word) begin
            if (fail_r != FAIL_MAX) begin
              fail_nxt = fail_r + 16'd1;
            end
            q_job_o.fail       = 1'b1;
            q_job_o.fail_count = (fail_r != FAIL_MAX) ? fail_r + 16'd1 : fail_r;
          end else begin
            q_job_o.fail       = 1'b0;
            q_job_o.bank       = wbank_r;
            q_job_o.mag_en     = diag7_r;
            q_job_o.fail_count = fail_r;
            busy_nxt[wbank_r]  = 1'b1;
            wbank_nxt          = ~wbank_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_IDLE;
      active_r <= 1'b0;
      crc_r    <= CRC_INIT;
      diag7_r  <= 1'b0;
      fail_r   <= '0;
      wbank_r  <= 1'b0;
      busy_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      crc_r    <= crc_nxt;
      diag7_r  <= diag7_nxt;
      fail_r   <= fail_nxt;
      wbank_r  <= wbank_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

// ===== rtl/ibfc_job_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfc_job_fifo
// Two-entry queue of checked frames between the front end and the sequencer.
// ----------------------------------------------------------------------------
module ibfc_job_fifo
  import ibfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       store_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign job_o   = store_r[rd_ptr_r];
  assign full_o  = (count_r == 2'd2);
  assign empty_o = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push_i) begin
      store_r[wr_ptr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_i) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push_i, pop_i})
        2'b10:   count_r <= 2'(count_r + 2'd1);
        2'b01:   count_r <= 2'(count_r - 2'd1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/ibfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfc_back
// Result sequencer: holds the banked sample store and walks the channels
// of each checked frame into a one-entry output register.
// ----------------------------------------------------------------------------
module ibfc_back
  import ibfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_wr_t           mem_wr_i,
  input  logic              q_empty_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  output bank_rel_t         rel_o,
  input  logic              pop_i,
  output logic              out_valid_o,
  output logic              status_o,
  output logic [CH_W-1:0]   channel_o,
  output logic [WORD_W-1:0] sample_value_o,
  output logic [WORD_W-1:0] fail_count_o,
  output logic              last_o
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t            state_r;
  job_t              job_r;
  logic [CH_W-1:0]   ch_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic [CH_W-1:0]   out_ch_r;
  logic              out_last_r;
  logic [WORD_W-1:0] out_count_r;
  logic [WORD_W-1:0] rd_r;
  logic [WORD_W-1:0] mem_r [NUM_BANKS][NUM_SAMPLES];

  logic            adv;
  logic            emit;
  logic            done;
  logic [CH_W-1:0] ch_step;

  function automatic logic [WORD_W-1:0] sext12(input logic [WORD_W-1:0] w);
    return {{4{w[11]}}, w[11:0]};
  endfunction

  assign adv     = !out_valid_r || pop_i;
  assign q_pop_o = (state_r == ST_IDLE) && !q_empty_i;
  assign emit    = (state_r == ST_RUN) && adv;
  assign done    = emit && (job_r.fail || ch_r == CH_TEMP);
  // Without fresh magnetometer and barometer data, skip straight to temperature.
  assign ch_step = (ch_r == CH_ACCEL_Z && !job_r.mag_en) ? CH_TEMP : 4'(ch_r + 4'd1);

  assign rel_o.valid = done && !job_r.fail;
  assign rel_o.bank  = job_r.bank;

  always_ff @(posedge clk) begin
    if (mem_wr_i.en) begin
      mem_r[mem_wr_i.bank][mem_wr_i.idx] <= mem_wr_i.data;
    end
    if (emit && !job_r.fail) begin
      rd_r <= mem_r[job_r.bank][ch_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop_o) begin
            job_r   <= q_job_i;
            ch_r    <= CH_GYRO_X;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit) begin
            if (done) begin
              state_r <= ST_IDLE;
            end else begin
              ch_r <= ch_step;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (emit) begin
        out_valid_r  <= 1'b1;
        out_status_r <= job_r.fail;
        out_ch_r     <= job_r.fail ? CH_GYRO_X : ch_r;
        out_last_r   <= done;
        out_count_r  <= job_r.fail_count;
      end else if (pop_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_r;
  assign status_o       = out_status_r;
  assign channel_o      = out_ch_r;
  assign last_o         = out_last_r;
  assign fail_count_o   = out_count_r;
  assign sample_value_o = out_status_r        ? '0 :
                          (out_ch_r == CH_TEMP) ? sext12(rd_r) : rd_r;

endmodule
